[design/lkvc_pkg.sv]
// Shared constants, types and the command struct of the LRU key/value cache.
package lkvc_pkg;

	localparam int NUM_ENTRIES = 4;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int RANK_W      = $clog2(NUM_ENTRIES);
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;

	// Slave tdata: key, then value.
	localparam int S_KEY_LSB   = 0;
	localparam int S_VAL_LSB   = KEY_W;
	localparam int S_TDATA_W   = 64;

	// Master tdata: found, value_out, evicted, evicted_key, zero padding.
	localparam int M_FOUND_BIT = 0;
	localparam int M_VOUT_LSB  = 1;
	localparam int M_EVICT_BIT = M_VOUT_LSB + VAL_W;
	localparam int M_EKEY_LSB  = M_EVICT_BIT + 1;
	localparam int M_USED_W    = M_EKEY_LSB + KEY_W;
	localparam int M_TDATA_W   = 72;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

[design/lru_key_value_cache_unit.sv]
// Top level of the LRU key/value cache: controller, datapath and stream ports.
//
//   Channel  Dir  Signals                         Contents
//   s_*      in   tvalid tready tdata[63:0] tuser  get/put request
//   m_*      out  tvalid tready tdata[71:0]        lookup/insert result
//
// An accepted transaction is registered, then processed in an update cycle that
// matches all entries in parallel and updates ranks; a new request is taken
// only in the idle state that follows that update, not while one is in flight.
// A finished result waits in the output register while the next request is
// taken. The update cycle stalls only while that register is full and m_tready
// is low. Reset clears valid bits and ranks at once; no clearing pass follows.
module lru_key_value_cache_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lkvc_pkg::S_TDATA_W-1:0]  s_tdata,  // key[31:0], value[63:32]
	input  logic                            s_tuser,  // op: 0 get, 1 put
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lkvc_pkg::M_TDATA_W-1:0]  m_tdata   // found[0], value_out[32:1],
	                                                  // evicted[33], evicted_key[65:34]
);
	import lkvc_pkg::*;

	ctrl_cmd_t              cmd;
	logic                   found;
	logic [VAL_W-1:0]       value_out;
	logic                   evicted;
	logic [KEY_W-1:0]       evicted_key;
	logic [NUM_ENTRIES-1:0] valid_mask;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	lkvc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_op       (s_tuser),
		.in_key      (s_tdata[S_KEY_LSB +: KEY_W]),
		.in_value    (s_tdata[S_VAL_LSB +: VAL_W]),
		.found       (found),
		.value_out   (value_out),
		.evicted     (evicted),
		.evicted_key (evicted_key),
		.valid_mask  (valid_mask)
	);

	assign m_tdata = {{(M_TDATA_W - M_USED_W){1'b0}}, evicted_key, evicted, value_out, found};

	// Entries are never freed, so the number of valid entries never drops.
	a_valid_grows: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_mask) >= $countones($past(valid_mask)))
		else $error("valid entry count decreased");

	// Only one request is in flight: an accepted request blocks the next one.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in flight");

	// A result is never written over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !(m_tvalid && !m_tready))
		else $error("result register overwritten");

	// An eviction only happens on a miss with the store full.
	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> !(evicted && found) && (!evicted || (&valid_mask)))
		else $error("eviction on a hit or with a free entry");

endmodule

[design/lkvc_ctrl.sv]
// Controller state machine of the LRU key/value cache.
module lkvc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output lkvc_pkg::ctrl_cmd_t cmd
);
	import lkvc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// The result register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_EXEC: begin
				cmd.exec = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

[design/lkvc_datapath.sv]
// Entry store, parallel key match, recency ranks and result register.
module lkvc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lkvc_pkg::ctrl_cmd_t               cmd,
	input  logic                              in_op,
	input  logic [lkvc_pkg::KEY_W-1:0]        in_key,
	input  logic [lkvc_pkg::VAL_W-1:0]        in_value,
	output logic                              found,
	output logic [lkvc_pkg::VAL_W-1:0]        value_out,
	output logic                              evicted,
	output logic [lkvc_pkg::KEY_W-1:0]        evicted_key,
	output logic [lkvc_pkg::NUM_ENTRIES-1:0]  valid_mask
);
	import lkvc_pkg::*;

	localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(NUM_ENTRIES - 1);

	// Item register.
	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	// Entry store.
	logic [KEY_W-1:0]  entry_key_q   [NUM_ENTRIES];
	logic [VAL_W-1:0]  entry_value_q [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] valid_q;
	logic [RANK_W-1:0] rank_q [NUM_ENTRIES];

	// Result register.
	logic             found_q;
	logic [VAL_W-1:0] value_out_q;
	logic             evicted_q;
	logic [KEY_W-1:0] evicted_key_q;

	logic [NUM_ENTRIES-1:0] hit_vec;
	logic [IDX_W-1:0]       hit_idx;
	logic [IDX_W-1:0]       free_idx;
	logic [IDX_W-1:0]       lru_idx;
	logic [IDX_W-1:0]       slot;
	logic                   hit;
	logic                   full;
	logic                   touch;
	logic                   age_all;
	logic                   do_evict;
	logic [RANK_W-1:0]      slot_rank;

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		lru_idx  = '0;
		for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
			hit_vec[i] = valid_q[i] && (entry_key_q[i] == key_q);
			if (hit_vec[i]) hit_idx = IDX_W'(i);
			if (!valid_q[i]) free_idx = IDX_W'(i);
			if (valid_q[i] && (rank_q[i] == RANK_LAST)) lru_idx = IDX_W'(i);
		end
	end

	assign hit      = |hit_vec;
	assign full     = &valid_q;
	assign touch    = hit || (op_q == OP_PUT);
	assign age_all  = (op_q == OP_PUT) && !hit && !full;
	assign do_evict = (op_q == OP_PUT) && !hit && full;

	always_comb begin
		if (hit) slot = hit_idx;
		else if (full) slot = lru_idx;
		else slot = free_idx;
	end

	assign slot_rank = rank_q[slot];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_op;
			key_q   <= in_key;
			value_q <= in_value;
		end
		if (cmd.exec) begin
			if (op_q == OP_PUT) begin
				entry_key_q[slot]   <= key_q;
				entry_value_q[slot] <= value_q;
			end
			found_q       <= hit;
			evicted_q     <= do_evict;
			evicted_key_q <= do_evict ? entry_key_q[lru_idx] : '0;
			if (op_q == OP_PUT) value_out_q <= '0;
			else if (hit) value_out_q <= entry_value_q[hit_idx];
			else value_out_q <= '1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < NUM_ENTRIES; i++) rank_q[i] <= '0;
		end else if (cmd.exec && touch) begin
			// Entries more recent than the touched one age by one step.
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if ((IDX_W'(i) != slot) && valid_q[i] &&
				    (age_all || (rank_q[i] < slot_rank))) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
			rank_q[slot]  <= '0;
			valid_q[slot] <= 1'b1;
		end
	end

	assign found       = found_q;
	assign value_out   = value_out_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;
	assign valid_mask  = valid_q;

endmodule
